// File: rtl/calendar_day_number_convert_defines.svh
// Assertion macros for the calendar day number converter
`ifndef CALENDAR_DAY_NUMBER_CONVERT_DEFINES_SVH
`define CALENDAR_DAY_NUMBER_CONVERT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clock, off during reset
`define CDN_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("calendar_day_number_convert: check failed");
// next-cycle implication
`define CDN_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("calendar_day_number_convert: check failed");
`else
`define CDN_ASSERT_IMPLY(label, ante, cons)
`define CDN_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/cdn_pkg.sv
// Types, constants and calendar tables for the calendar day number converter
package cdn_pkg;

   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned DN_W    = 22;

   // pipeline registers, output register included
   localparam int unsigned STAGES = 7;

   localparam logic OP_DATE_TO_NUM = 1'b0;
   localparam logic OP_NUM_TO_DATE = 1'b1;

   localparam int unsigned DAYS_400Y = 146097;
   localparam int unsigned DAYS_100Y = 36524;
   localparam int unsigned DAYS_4Y   = 1461;
   localparam int unsigned DAYS_1Y   = 365;

   // days before 1 January of a year, up to the largest 14-bit year
   localparam int unsigned YD_W = 23;

   // rounded-up reciprocals: floor(x * K >> S) is exact over the operand range
   localparam int unsigned S100   = 21;
   localparam int unsigned K100   = ((1 << S100) + 99) / 100;
   localparam int unsigned K100_W = 15;
   localparam int unsigned P100_W = YEAR_W + K100_W;

   localparam int unsigned S400   = 40;
   localparam longint unsigned K400 =
      ((64'd1 << S400) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y);
   localparam int unsigned K400_W = 23;
   localparam int unsigned P400_W = DN_W + K400_W;

   localparam int unsigned R100Y_W = 16;   // remainder within a 100-year block
   localparam int unsigned S4      = 27;
   localparam int unsigned K4      = ((1 << S4) + DAYS_4Y - 1) / DAYS_4Y;
   localparam int unsigned K4_W    = 17;
   localparam int unsigned P4_W    = R100Y_W + K4_W;

   typedef struct packed {
      logic               opcode;
      logic [YEAR_W-1:0]  in_year;
      logic [MONTH_W-1:0] in_month;
      logic [DAY_W-1:0]   in_day;
      logic [DN_W-1:0]    in_day_number;
   } req_type;

   typedef struct packed {
      logic [DN_W-1:0]    out_day_number;
      logic [YEAR_W-1:0]  out_year;
      logic [MONTH_W-1:0] out_month;
      logic [DAY_W-1:0]   out_day;
      logic               leap_year;
      logic               range_error;
   } rsp_type;

   // days in the year before the first of month m
   function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m, input logic leap);
      logic [8:0] base;
      case (m)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      return base + ((leap && m >= 4'd3 && m <= 4'd12) ? 9'd1 : 9'd0);
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
      logic [DAY_W-1:0] len;
      case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/cdn_date_to_num.sv
// Date to day number datapath, padded to the full pipeline depth
module cdn_date_to_num #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  logic                         clock,
   input  logic [cdn_pkg::STAGES-2:0]   en,
   input  cdn_pkg::req_type             req_data,
   output cdn_pkg::rsp_type             res
);
   import cdn_pkg::*;

   localparam logic [15:0] MaxYear = 16'(MAX_YEAR);

   // stage 0: p = year - 1 and its reciprocal product for p / 100
   logic [YEAR_W-1:0]  s0_p_in, s0_p_ff;
   logic [P100_W-1:0]  s0_prod_in, s0_prod_ff;
   logic               s0_ok_in, s0_ok_ff;
   logic [MONTH_W-1:0] s0_month_ff;
   logic [DAY_W-1:0]   s0_day_ff;

   always_comb begin
      s0_p_in    = req_data.in_year - YEAR_W'(1);
      s0_prod_in = P100_W'(s0_p_in) * P100_W'(K100);
      s0_ok_in   = (req_data.in_year != '0) && ({2'b00, req_data.in_year} <= MaxYear) &&
                   (req_data.in_month >= 4'd1) && (req_data.in_month <= 4'd12) &&
                   (req_data.in_day != '0);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_p_ff     <= s0_p_in;
         s0_prod_ff  <= s0_prod_in;
         s0_ok_ff    <= s0_ok_in;
         s0_month_ff <= req_data.in_month;
         s0_day_ff   <= req_data.in_day;
      end
   end

   // stage 1: days before the year and the leap flag
   logic [7:0]         q100;
   logic [6:0]         r100;
   logic [YD_W-1:0]    s1_ydays_in, s1_ydays_ff;
   logic               s1_leap_in, s1_leap_ff;
   logic               s1_ok_ff;
   logic [MONTH_W-1:0] s1_month_ff;
   logic [DAY_W-1:0]   s1_day_ff;

   always_comb begin
      q100 = s0_prod_ff[P100_W-1:S100];
      r100 = 7'(s0_p_ff - YEAR_W'(q100) * YEAR_W'(100));
      // year divisible by 4 <=> p mod 4 = 3, by 100 <=> p mod 100 = 99
      s1_leap_in  = (s0_p_ff[1:0] == 2'b11) && ((r100 != 7'd99) || (q100[1:0] == 2'b11));
      s1_ydays_in = YD_W'(s0_p_ff) * YD_W'(DAYS_1Y) + YD_W'(s0_p_ff >> 2)
                    - YD_W'(q100) + YD_W'(q100 >> 2);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_ydays_ff <= s1_ydays_in;
         s1_leap_ff  <= s1_leap_in;
         s1_ok_ff    <= s0_ok_ff;
         s1_month_ff <= s0_month_ff;
         s1_day_ff   <= s0_day_ff;
      end
   end

   // stage 2: day check and final sum
   logic [8:0]      doy;
   logic [YD_W-1:0] dn;
   rsp_type         s2_res_in;
   rsp_type         pipe_ff [2:STAGES-2];

   always_comb begin
      doy       = month_start(s1_month_ff, s1_leap_ff) + 9'(s1_day_ff) - 9'd1;
      dn        = s1_ydays_ff + YD_W'(doy);
      s2_res_in = '0;
      if (s1_ok_ff && (s1_day_ff <= month_len(s1_month_ff, s1_leap_ff))) begin
         s2_res_in.out_day_number = DN_W'(dn);
         s2_res_in.leap_year      = s1_leap_ff;
      end else begin
         s2_res_in.range_error = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         pipe_ff[2] <= s2_res_in;
      end
   end

   // delay to line up with the day number to date path
   for (genvar k = 3; k <= STAGES-2; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (en[k]) begin
            pipe_ff[k] <= pipe_ff[k-1];
         end
      end
   end

   assign res = pipe_ff[STAGES-2];

endmodule

// File: rtl/cdn_num_to_date.sv
// Day number to date datapath: 400/100/4/1-year decomposition, then month search
module cdn_num_to_date #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  logic                         clock,
   input  logic [cdn_pkg::STAGES-2:0]   en,
   input  logic [cdn_pkg::DN_W-1:0]     day_number,
   output cdn_pkg::rsp_type             res
);
   import cdn_pkg::*;

   localparam int unsigned LastDay =
      MAX_YEAR * DAYS_1Y + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400 - 1;

   // stage 0: reciprocal product for the 400-year count
   logic [DN_W-1:0]   s0_dn_ff;
   logic [P400_W-1:0] s0_prod_ff;
   logic              s0_err_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_dn_ff   <= day_number;
         s0_prod_ff <= P400_W'(day_number) * P400_W'(K400);
         s0_err_ff  <= {10'b0, day_number} > LastDay;
      end
   end

   // stage 1: remainder within the 400-year block
   logic [4:0]  q400;
   logic [17:0] s1_r400_in, s1_r400_ff;
   logic [4:0]  s1_n400_ff;
   logic        s1_err_ff;

   always_comb begin
      q400       = s0_prod_ff[S400+4:S400];
      s1_r400_in = 18'(s0_dn_ff - DN_W'(q400) * DN_W'(DAYS_400Y));
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_r400_ff <= s1_r400_in;
         s1_n400_ff <= q400;
         s1_err_ff  <= s0_err_ff;
      end
   end

   // stage 2: 100-year count, capped at 3 for the last day of a 400-year block
   logic [1:0]         s2_n100_in, s2_n100_ff;
   logic [R100Y_W-1:0] s2_r2_in, s2_r2_ff;
   logic [4:0]         s2_n400_ff;
   logic               s2_err_ff;

   always_comb begin
      if (s1_r400_ff >= 18'(3 * DAYS_100Y)) begin
         s2_n100_in = 2'd3;
      end else if (s1_r400_ff >= 18'(2 * DAYS_100Y)) begin
         s2_n100_in = 2'd2;
      end else if (s1_r400_ff >= 18'(DAYS_100Y)) begin
         s2_n100_in = 2'd1;
      end else begin
         s2_n100_in = 2'd0;
      end
      s2_r2_in = R100Y_W'(s1_r400_ff - 18'(s2_n100_in) * 18'(DAYS_100Y));
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_n100_ff <= s2_n100_in;
         s2_r2_ff   <= s2_r2_in;
         s2_n400_ff <= s1_n400_ff;
         s2_err_ff  <= s1_err_ff;
      end
   end

   // stage 3: reciprocal product for the 4-year count
   logic [P4_W-1:0]    s3_prod_ff;
   logic [R100Y_W-1:0] s3_r2_ff;
   logic [4:0]         s3_n400_ff;
   logic [1:0]         s3_n100_ff;
   logic               s3_err_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_prod_ff <= P4_W'(s2_r2_ff) * P4_W'(K4);
         s3_r2_ff   <= s2_r2_ff;
         s3_n400_ff <= s2_n400_ff;
         s3_n100_ff <= s2_n100_ff;
         s3_err_ff  <= s2_err_ff;
      end
   end

   // stage 4: remainder within the 4-year block
   logic [4:0]  n4;
   logic [10:0] s4_r3_in, s4_r3_ff;
   logic [4:0]  s4_n4_ff, s4_n400_ff;
   logic [1:0]  s4_n100_ff;
   logic        s4_err_ff;

   always_comb begin
      n4       = s3_prod_ff[S4+4:S4];
      s4_r3_in = 11'(s3_r2_ff - R100Y_W'(n4) * R100Y_W'(DAYS_4Y));
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_r3_ff   <= s4_r3_in;
         s4_n4_ff   <= n4;
         s4_n400_ff <= s3_n400_ff;
         s4_n100_ff <= s3_n100_ff;
         s4_err_ff  <= s3_err_ff;
      end
   end

   // stage 5: year, day of year and leap flag
   logic [1:0]        n1;
   logic [8:0]        s5_doy_in, s5_doy_ff;
   logic [YEAR_W-1:0] s5_year_in, s5_year_ff;
   logic              s5_leap_in, s5_leap_ff;
   logic              s5_err_ff;

   always_comb begin
      if (s4_r3_ff >= 11'(3 * DAYS_1Y)) begin
         n1 = 2'd3;
      end else if (s4_r3_ff >= 11'(2 * DAYS_1Y)) begin
         n1 = 2'd2;
      end else if (s4_r3_ff >= 11'(DAYS_1Y)) begin
         n1 = 2'd1;
      end else begin
         n1 = 2'd0;
      end
      s5_doy_in  = 9'(s4_r3_ff - 11'(n1) * 11'(DAYS_1Y));
      s5_year_in = YEAR_W'(s4_n400_ff) * YEAR_W'(400) + YEAR_W'(s4_n100_ff) * YEAR_W'(100)
                   + YEAR_W'({s4_n4_ff, 2'b00}) + YEAR_W'(n1) + YEAR_W'(1);
      // last year of a 4-year block is leap, except a century year not on a 400 boundary
      s5_leap_in = (n1 == 2'd3) && ((s4_n4_ff != 5'd24) || (s4_n100_ff == 2'd3));
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_doy_ff  <= s5_doy_in;
         s5_year_ff <= s5_year_in;
         s5_leap_ff <= s5_leap_in;
         s5_err_ff  <= s4_err_ff;
      end
   end

   // month search, feeds the output register
   logic [MONTH_W-1:0] mon;

   always_comb begin
      mon = 4'd1;
      for (int k = 2; k <= 12; k++) begin
         if (s5_doy_ff >= month_start(MONTH_W'(k), s5_leap_ff)) begin
            mon = MONTH_W'(k);
         end
      end
      res = '0;
      if (s5_err_ff) begin
         res.range_error = 1'b1;
      end else begin
         res.out_year  = s5_year_ff;
         res.out_month = mon;
         res.out_day   = DAY_W'(s5_doy_ff - month_start(mon, s5_leap_ff)) + DAY_W'(1);
         res.leap_year = s5_leap_ff;
      end
   end

endmodule

// File: rtl/calendar_day_number_convert.sv
// Top level of the calendar day number converter
//
// Converts a proleptic Gregorian date to a day number counted from 0001-01-01
// (opcode 0) or a day number back to year, month and day (opcode 1), with a
// leap-year flag and a range error for invalid dates, years above MAX_YEAR or
// day numbers past the last day of MAX_YEAR. One transfer is taken every
// clock cycle while req_stall is low; the pipeline depth is set by the day
// number to date path (two reciprocal multiplies, each followed by a
// remainder step, then the month search). A stall on the result side holds
// the pipeline in place and backs up onto req_stall only once every stage
// holds an item.
`include "calendar_day_number_convert_defines.svh"

module calendar_day_number_convert #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cdn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cdn_pkg::rsp_type rsp_data
);
   import cdn_pkg::*;

   logic [STAGES-1:0] v_in, v_ff;
   logic [STAGES-1:0] en;
   logic              op_ff [0:STAGES-2];
   rsp_type           d2n_res, n2d_res;
   rsp_type           rsp_in, rsp_ff;

   // a stage loads when it is empty or its contents move on
   always_comb begin
      en[STAGES-1] = !v_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES-2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_comb begin
      v_in = v_ff;
      if (en[0]) begin
         v_in[0] = req_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (en[k]) begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         op_ff[0] <= req_data.opcode;
      end
   end

   for (genvar k = 1; k <= STAGES-2; k++) begin : g_op
      always_ff @(posedge clock) begin
         if (en[k]) begin
            op_ff[k] <= op_ff[k-1];
         end
      end
   end

   cdn_date_to_num #(
      .MAX_YEAR (MAX_YEAR)
   ) u_date_to_num (
      .clock    (clock),
      .en       (en[STAGES-2:0]),
      .req_data (req_data),
      .res      (d2n_res)
   );

   cdn_num_to_date #(
      .MAX_YEAR (MAX_YEAR)
   ) u_num_to_date (
      .clock      (clock),
      .en         (en[STAGES-2:0]),
      .day_number (req_data.in_day_number),
      .res        (n2d_res)
   );

   assign rsp_in = (op_ff[STAGES-2] == OP_NUM_TO_DATE) ? n2d_res : d2n_res;

   always_ff @(posedge clock) begin
      if (en[STAGES-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[STAGES-1];
   assign rsp_data  = rsp_ff;

   `CDN_ASSERT_IMPLY(a_err_clears_fields, rsp_valid && rsp_data.range_error, (rsp_data.out_day_number == '0) && (rsp_data.out_year == '0) && (rsp_data.out_month == '0) && (rsp_data.out_day == '0) && !rsp_data.leap_year)
   `CDN_ASSERT_IMPLY(a_date_sane, rsp_valid && !rsp_data.range_error && (rsp_data.out_month != '0), (rsp_data.out_month <= 4'd12) && (rsp_data.out_day != '0) && (rsp_data.out_year != '0))
   `CDN_ASSERT_IMPLY(a_full_backs_up, (&v_ff) && rsp_stall, req_stall)
   `CDN_ASSERT_NEXT(a_drain_to_output, v_ff[STAGES-2] && !rsp_valid, rsp_valid)

endmodule
